/* rtl/core/sts_pkg.sv */
// Shared constants for the sorted table search core.
package sts_pkg;

    // Default sizing of the table
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_BITS  = 32;

    // Fixed field widths
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

endpackage

/* rtl/core/sts_req_if.sv */
// Request channel: table writes and key searches.
interface sts_req_if
    import sts_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic        [SLOT_W-1:0]     slot;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output slot, output value, input ready);
    modport sink   (input valid, input cmd, input slot, input value, output ready);
endinterface

/* rtl/core/sts_rsp_if.sv */
// Response channel: one search outcome per transaction.
interface sts_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

/* rtl/core/sts_ram.sv */
// Generic single-write, single-read RAM with a registered read.
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/sorted_table_binary_search_core.sv */
// Top level of the sorted table search core: FSM around one table RAM.
//
// Usage: the req channel carries transactions of cmd, slot and value. A write
// (cmd 0) stores value at table index slot and gives no response;
// slots at or beyond the table depth are dropped. A search (cmd 1) looks for
// value among the first entries_in_use entries, which software keeps in
// ascending signed order, and gives one response transaction with found.
// entries_in_use is loaded through cfg_we/cfg_wdata; the user must do so only
// while the core is idle, as the core does not enforce it. Counts above the
// depth are clamped to the depth. A search is accepted in IDLE, then does one
// table probe per cycle in PROBE (one RAM read each, at most log2(depth)+1
// probes, 11 for 1024 entries), then loads the output register in FINISH. An
// empty table skips the probes. The single RAM read port sets the probe rate.
// The core takes a new request whenever its search engine is idle, even while
// an earlier response waits in the output register; if the receiver stalls, a
// finished search holds its result until the output register frees up.
// Reset clears the entry count, the FSM and the output valid; table contents
// are undefined until written.
module sorted_table_binary_search_core
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEFAULT_VALUE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    sts_req_if.sink            req,
    sts_rsp_if.source          rsp
);
    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int BND_W      = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_CMP_W = (BND_W > SLOT_W) ? BND_W : SLOT_W;
    localparam int CNT_CMP_W  = (BND_W > COUNT_W) ? BND_W : COUNT_W;

    // FSM codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [COUNT_W-1:0]           entries_reg;
    logic [BND_W-1:0]             lo_reg, lo_next;
    logic [BND_W-1:0]             hi_reg, hi_next;
    logic [ADDR_W-1:0]            mid_reg, mid_next;
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic                         hit_reg, hit_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg, found_next;

    logic                         in_fire;
    logic                         out_free;
    logic [SLOT_CMP_W-1:0]        slot_ext;
    logic                         slot_ok;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [VALUE_BITS-1:0]        ram_rdata;
    logic [BND_W-1:0]             hi_cap;
    logic [BND_W:0]               init_sum;
    logic signed [VALUE_BITS-1:0] probe;
    logic                         probe_lt;
    logic                         probe_eq;
    logic [BND_W-1:0]             lo_step;
    logic [BND_W-1:0]             hi_step;
    logic [BND_W:0]               step_sum;

    // Handshake
    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.found = found_reg;

    // Write path with slot range check
    assign slot_ext = SLOT_CMP_W'(req.slot);
    assign slot_ok  = slot_ext < SLOT_CMP_W'(TABLE_DEPTH);
    assign ram_we   = in_fire && (req.cmd == CMD_WRITE) && slot_ok;

    // Upper bound clamped to the depth
    assign hi_cap   = (CNT_CMP_W'(entries_reg) > CNT_CMP_W'(TABLE_DEPTH))
                    ? BND_W'(TABLE_DEPTH) : BND_W'(entries_reg);
    assign init_sum = (BND_W + 1)'(hi_cap);

    // Probe compare and bound update
    assign probe    = $signed(ram_rdata);
    assign probe_lt = probe < key_reg;
    assign probe_eq = probe == key_reg;
    assign lo_step  = probe_lt ? (BND_W'(mid_reg) + BND_W'(1)) : lo_reg;
    assign hi_step  = probe_lt ? hi_reg : BND_W'(mid_reg);
    assign step_sum = (BND_W + 1)'(lo_step) + (BND_W + 1)'(hi_step);

    // Read address: first midpoint when idle, next midpoint while probing
    assign ram_raddr = (state_reg == ST_IDLE) ? init_sum[ADDR_W:1] : step_sum[ADDR_W:1];

    sts_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[ADDR_W-1:0]),
        .wdata (req.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Search FSM
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req.cmd == CMD_SEARCH))
                begin
                    key_next = req.value;
                    lo_next  = '0;
                    hi_next  = hi_cap;
                    mid_next = init_sum[ADDR_W:1];
                    if (hi_cap == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (probe_eq)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (lo_step < hi_step)
                begin
                    lo_next  = lo_step;
                    hi_next  = hi_step;
                    mid_next = step_sum[ADDR_W:1];
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            entries_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
    end
endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the sorted table search core.

typedef logic signed [sts_pkg::DEFAULT_VALUE_BITS-1:0] word_t;

// Mirrors the table and entry count, predicts each search outcome, checks responses
class lookup_checker;
    word_t                         entry_mirror [sts_pkg::DEFAULT_TABLE_DEPTH];
    logic [sts_pkg::COUNT_W-1:0]   count_in_use;
    bit                            pending_found [$];
    int                            mismatches;

    function new();
        foreach (entry_mirror[i])
        begin
            entry_mirror[i] = '0;
        end
        count_in_use = '0;
        mismatches   = 0;
    endfunction

    function void load_count(logic [sts_pkg::COUNT_W-1:0] n);
        count_in_use = n;
    endfunction

    // Probe sequence: low bound, exclusive high bound, midpoint compare
    function bit predict_found(word_t key);
        int lo;
        int hi;
        int mid;
        bit hit;
        lo  = 0;
        hi  = (count_in_use > sts_pkg::DEFAULT_TABLE_DEPTH) ?
              sts_pkg::DEFAULT_TABLE_DEPTH : int'(count_in_use);
        hit = 1'b0;
        while (lo < hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (entry_mirror[mid] < key)
                lo = mid + 1;
            else if (entry_mirror[mid] > key)
                hi = mid;
            else
                hit = 1'b1;
        end
        return hit;
    endfunction

    function void note_request(logic cmd, logic [sts_pkg::SLOT_W-1:0] slot, word_t value);
        if (cmd == sts_pkg::CMD_WRITE)
        begin
            // slots past the depth are dropped
            if (slot < sts_pkg::DEFAULT_TABLE_DEPTH)
                entry_mirror[slot] = value;
        end
        else
            pending_found.push_back(predict_found(value));
    endfunction

    function void check_response(logic found);
        bit want;
        if (pending_found.size() == 0)
        begin
            $display("%0t: unexpected response: expected none, actual found=%0b", $time, found);
            mismatches++;
            return;
        end
        want = pending_found.pop_front();
        if (found !== want)
        begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, want, found);
            mismatches++;
        end
    endfunction

    function int pending();
        return pending_found.size();
    endfunction
endclass

module tb_top;
    import sts_pkg::*;

    localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int VBITS        = DEFAULT_VALUE_BITS;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int CORE_LATENCY = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int ITEM_TARGET  = 1770;
    localparam word_t WORD_MIN  = {1'b1, {(VBITS-1){1'b0}}};
    localparam word_t WORD_MAX  = {1'b0, {(VBITS-1){1'b1}}};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    sts_req_if #(.VALUE_BITS(VBITS)) req_ch ();
    sts_rsp_if                       rsp_ch ();

    sorted_table_binary_search_core #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_BITS  (VBITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    lookup_checker sb = new();

    word_t written_vals [DEPTH];
    int    items_sent  = 0;
    int    burst_left  = 0;
    int    idle_cycles = 0;
    int    sink_mode   = 0;
    int    sink_hold   = 0;
    int    sink_tick   = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Monitor: config writes, accepted requests and responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_we)
            begin
                sb.load_count(cfg_wdata);
                idle_cycles = 0;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_response(rsp_ch.found);
                idle_cycles = 0;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_request(req_ch.cmd, req_ch.slot, req_ch.value);
                idle_cycles = 0;
            end
        end
    end

    // Response back-pressure: free flow, coin flip, heavy stall, periodic
    always @(negedge clk)
    begin
        if (sink_hold == 0)
        begin
            sink_mode = $urandom_range(0, 3);
            sink_hold = $urandom_range(20, 200);
        end
        else
            sink_hold--;
        sink_tick++;
        case (sink_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= ((sink_tick % 3) != 0);
        endcase
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[sorted_table_binary_search_core] ERROR");
        $finish;
    end

    // Drive one request in bursts with random gaps; returns once accepted
    task automatic send_req(input logic cmd, input logic [SLOT_W-1:0] slot, input word_t value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.slot  <= slot;
        req_ch.value <= value;
        if (cmd == CMD_WRITE)
            written_vals[slot] = value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Load the entry count once the core has drained
    task automatic set_count(input int n);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (CORE_LATENCY) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(n);
        @(negedge clk);
        cfg_we     <= 1'b0;
        burst_left = 0;
    endtask

    // One phase: set count, write an ascending run from slot 0, then search
    task automatic run_phase(input int count, input int n_fill, input int n_search);
        longint acc;
        longint step_max;
        int     lim;
        int     idx;
        int     pick;
        word_t  key;
        set_count(count);

        // ascending fill; sometimes starts at the minimum, ends at the maximum, or is dense
        acc = -64'sd2147483648;
        if ($urandom_range(0, 2) != 0)
            acc += $urandom_range(0, 32'h3FFF_FFFF);
        step_max = (64'sd2147483647 - acc) / ((n_fill > 1) ? n_fill - 1 : 1);
        if ($urandom_range(0, 3) == 0 && step_max > 3)
            step_max = 3;
        for (int i = 0; i < n_fill; i++)
        begin
            if (i > 0)
                acc += $urandom_range(0, 32'(step_max));
            if (i == n_fill - 1 && $urandom_range(0, 3) == 0)
                acc = 64'sd2147483647;
            send_req(CMD_WRITE, SLOT_W'(i), word_t'(acc));
        end

        // searches: hits, near misses, stale entries, extremes, noise writes
        lim = (count > DEPTH) ? DEPTH : count;
        repeat (n_search)
        begin
            pick = $urandom_range(0, 99);
            idx  = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
            if (pick < 5)
                send_req(CMD_WRITE, SLOT_W'($urandom), word_t'($urandom));
            else
            begin
                if (pick < 50 && lim > 0)
                    key = written_vals[idx];
                else if (pick < 65 && lim > 0)
                    key = written_vals[idx] + ((pick % 2) ? 1 : -1);
                else if (pick < 75)
                    key = written_vals[$urandom_range(0, DEPTH - 1)];
                else if (pick < 85)
                begin
                    case ($urandom_range(0, 3))
                        0:       key = WORD_MIN;
                        1:       key = WORD_MAX;
                        2:       key = '0;
                        default: key = '1;
                    endcase
                end
                else
                    key = word_t'($urandom);
                send_req(CMD_SEARCH, SLOT_W'($urandom), key);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int n_fill;
        int n_count;
        int pick;
        foreach (written_vals[i])
        begin
            written_vals[i] = '0;
        end
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_WRITE;
        req_ch.slot  = '0;
        req_ch.value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table after reset never hits
        send_req(CMD_SEARCH, '0, WORD_MIN);
        send_req(CMD_SEARCH, '1, WORD_MAX);
        send_req(CMD_SEARCH, '0, '0);

        // small sorted table with both extremes and a duplicate
        send_req(CMD_WRITE, SLOT_W'(0), WORD_MIN);
        send_req(CMD_WRITE, SLOT_W'(1), word_t'(-5));
        send_req(CMD_WRITE, SLOT_W'(2), word_t'(0));
        send_req(CMD_WRITE, SLOT_W'(3), word_t'(7));
        send_req(CMD_WRITE, SLOT_W'(4), word_t'(7));
        send_req(CMD_WRITE, SLOT_W'(5), WORD_MAX);
        set_count(6);
        send_req(CMD_SEARCH, '0, WORD_MIN);
        send_req(CMD_SEARCH, '1, WORD_MAX);
        send_req(CMD_SEARCH, '0, word_t'(0));
        send_req(CMD_SEARCH, '0, word_t'(7));
        send_req(CMD_SEARCH, '0, word_t'(-4));
        send_req(CMD_SEARCH, '0, WORD_MIN + 1);
        send_req(CMD_SEARCH, '0, WORD_MAX - 1);

        // out-of-order entry: search still follows its probe path
        send_req(CMD_WRITE, SLOT_W'(2), word_t'(100));
        send_req(CMD_SEARCH, '0, word_t'(100));
        send_req(CMD_SEARCH, '0, word_t'(-5));

        // single entry
        set_count(1);
        send_req(CMD_SEARCH, '0, WORD_MIN);
        send_req(CMD_SEARCH, '0, word_t'(0));

        // full table, then counts past and just below the depth
        run_phase(DEPTH, DEPTH, 30);
        run_phase(COUNT_MAX, 0, 25);
        run_phase(DEPTH + 1, 0, 15);
        run_phase(DEPTH - 1, 0, 15);

        // mostly small tables; some with stale tails or saturated counts
        while (items_sent < ITEM_TARGET)
        begin
            n_fill = $urandom_range(1, 40);
            pick   = $urandom_range(0, 9);
            if (pick == 0)
                n_count = 0;
            else if (pick == 1)
                n_count = $urandom_range(n_fill, COUNT_MAX);
            else if (pick == 2)
                n_count = $urandom_range(0, n_fill);
            else
                n_count = n_fill;
            run_phase(n_count, n_fill, $urandom_range(8, 30));
        end

        // drain and settle
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (CORE_LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[sorted_table_binary_search_core] OK");
        else
            $display("[sorted_table_binary_search_core] ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/sts_pkg.sv
rtl/core/sts_req_if.sv
rtl/core/sts_rsp_if.sv
rtl/core/sts_ram.sv
rtl/core/sorted_table_binary_search_core.sv
bench/tb_top.sv
